// File: hdl/cfm_pkg.sv
`timescale 1ns / 1ps

package cfm_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int GAIN_BITS = 7;
  localparam int CFG_INDEX_BITS = 8;

  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 7'd64;
  localparam logic [GAIN_BITS-1:0] FADER_CENTER = 7'd64;
  localparam logic [GAIN_BITS-1:0] FADER_TOP = 7'd127;

  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_ONE = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_TWO = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MASTER_GAIN = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FADER_POSITION = 8'd3;

  typedef struct packed {
    logic [GAIN_BITS-1:0] gain_one;
    logic [GAIN_BITS-1:0] gain_two;
    logic [GAIN_BITS-1:0] master_gain;
    logic [GAIN_BITS-1:0] fader_position;
  } cfm_cfg_t;

  typedef struct packed {
    logic load;
    logic mul_x1;
    logic mul_n1;
    logic scale1;
    logic div_step;
    logic mul_x2;
    logic mul_n2;
    logic mix;
    logic finish;
  } cfm_cmd_t;

  typedef struct packed {
    logic div_need;
    logic div_done;
    logic out_free;
  } cfm_status_t;

endpackage

// File: hdl/cfm_if.sv
`timescale 1ns / 1ps

interface cfm_in_if #(
  parameter int SAMPLE_BITS = cfm_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_one;
  logic signed [SAMPLE_BITS-1:0] sample_two;
  logic                          one_active;
  logic                          two_active;
  logic                          period_last;

  modport source (
    output valid, sample_one, sample_two, one_active, two_active, period_last,
    input  ready
  );
  modport sink (
    input  valid, sample_one, sample_two, one_active, two_active, period_last,
    output ready
  );
endinterface

interface cfm_out_if #(
  parameter int SAMPLE_BITS = cfm_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] mixed_sample;
  logic signed [SAMPLE_BITS-1:0] peak_one;
  logic signed [SAMPLE_BITS-1:0] peak_two;
  logic                          peaks_updated;

  modport source (
    output valid, mixed_sample, peak_one, peak_two, peaks_updated,
    input  ready
  );
  modport sink (
    input  valid, mixed_sample, peak_one, peak_two, peaks_updated,
    output ready
  );
endinterface

interface cfm_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [cfm_pkg::CFG_INDEX_BITS-1:0]  index;
  logic [cfm_pkg::GAIN_BITS-1:0]       data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// File: hdl/two_channel_crossfade_mixer.sv
`timescale 1ns / 1ps
// Channel     Dir  Handshake                  Payload
// sample_in   in   valid/ready, transfer      sample_one, sample_two, one_active,
//                                             two_active, period_last
// mix_out     out  valid/ready, transfer      mixed_sample, peak_one, peak_two,
//                                             peaks_updated
// cfg         in   valid/ready (ready high)   index, data
//
// One item runs through the states MUL_X1, MUL_N1, SCALE1, MUL_X2, MUL_N2, MIX and
// FINISH, and through DIV after SCALE1 when both channels are active, the
// fader is right of center and channel one runs through the divide-by-63 loop (one
// step per six bits of the scaled sample, then a final step); one shared 7-bit gain
// multiplier forms every product.
// Reset is synchronous: gains and fader go to 64, peaks to zero, a new period starts.
// A full result register stalls the block in its last step; the next input
// transfer is taken while a result still waits on mix_out.

module two_channel_crossfade_mixer #(
  parameter int SAMPLE_BITS = cfm_pkg::SAMPLE_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  cfm_in_if.sink    sample_in,
  cfm_out_if.source mix_out,
  cfm_cfg_if.sink   cfg
);
  import cfm_pkg::*;

  cfm_cfg_t    regs;
  cfm_cmd_t    cmd;
  cfm_status_t status;

  cfm_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  cfm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample_in.valid),
    .in_ready (sample_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  cfm_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .regs          (regs),
    .cmd           (cmd),
    .status        (status),
    .sample_one    (sample_in.sample_one),
    .sample_two    (sample_in.sample_two),
    .one_active    (sample_in.one_active),
    .two_active    (sample_in.two_active),
    .period_last   (sample_in.period_last),
    .out_valid     (mix_out.valid),
    .out_ready     (mix_out.ready),
    .mixed_sample  (mix_out.mixed_sample),
    .peak_one      (mix_out.peak_one),
    .peak_two      (mix_out.peak_two),
    .peaks_updated (mix_out.peaks_updated)
  );

endmodule

// File: hdl/cfm_regs.sv
`timescale 1ns / 1ps

module cfm_regs (
  input  logic              clk,
  input  logic              rst,
  cfm_cfg_if.sink           cfg,
  output cfm_pkg::cfm_cfg_t regs
);
  import cfm_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.gain_one       <= GAIN_RESET;
      regs.gain_two       <= GAIN_RESET;
      regs.master_gain    <= GAIN_RESET;
      regs.fader_position <= GAIN_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_GAIN_ONE:       regs.gain_one       <= cfg.data;
        REG_GAIN_TWO:       regs.gain_two       <= cfg.data;
        REG_MASTER_GAIN:    regs.master_gain    <= cfg.data;
        REG_FADER_POSITION: regs.fader_position <= cfg.data;
        default: begin
        end
      endcase
    end
  end

endmodule

// File: hdl/cfm_ctrl.sv
`timescale 1ns / 1ps

module cfm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cfm_pkg::cfm_status_t status,
  output cfm_pkg::cfm_cmd_t    cmd
);
  import cfm_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_MUL_X1 = 9'b000000010,
    ST_MUL_N1 = 9'b000000100,
    ST_SCALE1 = 9'b000001000,
    ST_DIV    = 9'b000010000,
    ST_MUL_X2 = 9'b000100000,
    ST_MUL_N2 = 9'b001000000,
    ST_MIX    = 9'b010000000,
    ST_FINISH = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_MUL_X1;
      ST_MUL_X1: state_next = ST_MUL_N1;
      ST_MUL_N1: state_next = ST_SCALE1;
      ST_SCALE1: state_next = status.div_need ? ST_DIV : ST_MUL_X2;
      ST_DIV:    if (status.div_done) state_next = ST_MUL_X2;
      ST_MUL_X2: state_next = ST_MUL_N2;
      ST_MUL_N2: state_next = ST_MIX;
      ST_MIX:    state_next = ST_FINISH;
      ST_FINISH: if (status.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == ST_IDLE) && in_valid;
    cmd.mul_x1   = (state == ST_MUL_X1);
    cmd.mul_n1   = (state == ST_MUL_N1);
    cmd.scale1   = (state == ST_SCALE1);
    cmd.div_step = (state == ST_DIV);
    cmd.mul_x2   = (state == ST_MUL_X2);
    cmd.mul_n2   = (state == ST_MUL_N2);
    cmd.mix      = (state == ST_MIX);
    cmd.finish   = (state == ST_FINISH) && status.out_free;
  end

endmodule

// File: hdl/cfm_datapath.sv
`timescale 1ns / 1ps

module cfm_datapath #(
  parameter int SAMPLE_BITS = cfm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cfm_pkg::cfm_cfg_t             regs,
  input  cfm_pkg::cfm_cmd_t             cmd,
  output cfm_pkg::cfm_status_t          status,
  input  logic signed [SAMPLE_BITS-1:0] sample_one,
  input  logic signed [SAMPLE_BITS-1:0] sample_two,
  input  logic                          one_active,
  input  logic                          two_active,
  input  logic                          period_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] mixed_sample,
  output logic signed [SAMPLE_BITS-1:0] peak_one,
  output logic signed [SAMPLE_BITS-1:0] peak_two,
  output logic                          peaks_updated
);
  import cfm_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int OW = SB + GAIN_BITS;
  localparam int AW = SB + 2 * GAIN_BITS;
  localparam int MW = OW + GAIN_BITS + 1;
  localparam int DW = OW - 1;
  localparam logic signed [AW-1:0] SAT_HI = {{(AW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [AW-1:0] SAT_LO = ~SAT_HI;

  logic signed [SB-1:0] x1;
  logic signed [SB-1:0] x2;
  logic                 both;
  logic                 last;
  logic signed [AW-1:0] acc;
  logic signed [SB-1:0] c1;
  logic signed [SB-1:0] c2;
  logic                 neg;
  logic [DW-1:0]        r;
  logic [DW-1:0]        qacc;
  logic signed [SB-1:0] running_peak_one;
  logic signed [SB-1:0] running_peak_two;
  logic                 period_start;

  logic                 pos_hi;
  logic                 pos_lo;
  logic [GAIN_BITS-1:0] n1;
  logic [GAIN_BITS-1:0] n2;
  logic signed [OW-1:0] mul_a;
  logic [GAIN_BITS-1:0] mul_b;
  logic signed [MW-1:0] mul_p;
  logic signed [AW-1:0] acc_sh7;
  logic signed [AW-1:0] acc_sh13;
  logic signed [SB-1:0] c2_w;
  logic signed [SB:0]   sum;
  logic [DW-1:0]        u;
  logic [DW-1:0]        r_hi;
  logic [DW-1:0]        quot;
  logic signed [SB-1:0] mix_sat;
  logic signed [SB-1:0] peak1_next;
  logic signed [SB-1:0] peak2_next;
  logic                 out_free;

  assign pos_hi = regs.fader_position > FADER_CENTER;
  assign pos_lo = regs.fader_position < FADER_CENTER;
  assign n1 = (both && pos_hi) ? (FADER_TOP - regs.fader_position) : GAIN_BITS'(1);
  assign n2 = (both && pos_lo) ? regs.fader_position : GAIN_BITS'(1);

  assign acc_sh7  = acc >>> 7;
  assign acc_sh13 = acc >>> 13;
  assign c2_w = (both && pos_lo) ? acc_sh13[SB-1:0] : acc_sh7[SB-1:0];
  assign sum  = (SB+1)'(c1) + (SB+1)'(c2_w);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (1'b1)
      cmd.mul_x1: begin
        mul_a = OW'(x1);
        mul_b = regs.gain_one;
      end
      cmd.mul_n1: begin
        mul_a = acc[OW-1:0];
        mul_b = n1;
      end
      cmd.mul_x2: begin
        mul_a = OW'(x2);
        mul_b = regs.gain_two;
      end
      cmd.mul_n2: begin
        mul_a = acc[OW-1:0];
        mul_b = n2;
      end
      cmd.mix: begin
        mul_a = OW'(sum);
        mul_b = regs.master_gain;
      end
      default: begin
      end
    endcase
  end

  assign mul_p = MW'(mul_a) * MW'($signed({1'b0, mul_b}));

  assign u    = acc_sh7[OW-1] ? ~acc_sh7[DW-1:0] : acc_sh7[DW-1:0];
  assign r_hi = r >> 6;
  assign quot = qacc + DW'(r[5:0] == 6'h3f);

  always_comb begin
    if (acc_sh7 > SAT_HI) begin
      mix_sat = SAT_HI[SB-1:0];
    end else if (acc_sh7 < SAT_LO) begin
      mix_sat = SAT_LO[SB-1:0];
    end else begin
      mix_sat = acc_sh7[SB-1:0];
    end
  end

  assign peak1_next = (period_start || (c1 > running_peak_one)) ? c1 : running_peak_one;
  assign peak2_next = (period_start || (c2 > running_peak_two)) ? c2 : running_peak_two;

  assign out_free        = !out_valid || out_ready;
  assign status.div_need = both && pos_hi;
  assign status.div_done = (r_hi == '0);
  assign status.out_free = out_free;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x1   <= one_active ? sample_one : '0;
      x2   <= two_active ? sample_two : '0;
      both <= one_active && two_active;
      last <= period_last;
    end
    if (cmd.mul_x1 || cmd.mul_n1 || cmd.mul_x2 || cmd.mul_n2 || cmd.mix) begin
      acc <= mul_p[AW-1:0];
    end
    if (cmd.scale1) begin
      if (status.div_need) begin
        r    <= u;
        qacc <= '0;
        neg  <= acc_sh7[OW-1];
      end else begin
        c1 <= acc_sh7[SB-1:0];
      end
    end
    if (cmd.div_step) begin
      if (status.div_done) begin
        c1 <= neg ? ~quot[SB-1:0] : quot[SB-1:0];
      end else begin
        r    <= r_hi + DW'(r[5:0]);
        qacc <= qacc + r_hi;
      end
    end
    if (cmd.mix) begin
      c2 <= c2_w;
    end
    if (cmd.finish) begin
      mixed_sample  <= mix_sat;
      peaks_updated <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      period_start     <= 1'b1;
      running_peak_one <= '0;
      running_peak_two <= '0;
      peak_one         <= '0;
      peak_two         <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.finish) begin
        out_valid        <= 1'b1;
        running_peak_one <= peak1_next;
        running_peak_two <= peak2_next;
        period_start     <= last;
        if (last) begin
          peak_one <= peak1_next;
          peak_two <= peak2_next;
        end
      end
    end
  end

endmodule

// File: hdl/cfm_checker.sv
`timescale 1ns / 1ps

module cfm_checker #(
  parameter int SAMPLE_BITS = cfm_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] mixed_sample,
  input logic [SAMPLE_BITS-1:0] peak_one,
  input logic [SAMPLE_BITS-1:0] peak_two
);

  logic in_xfer;

  assign in_xfer = in_valid && in_ready;

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !in_ready)
    else $error("input ready after a transfer");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !$rose(out_valid))
    else $error("result one cycle after input transfer");

  a_result_then_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("not ready for input when result appears");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mixed_sample)
      && $stable(peak_one) && $stable(peak_two))
    else $error("stalled result changed");

endmodule

bind two_channel_crossfade_mixer cfm_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_cfm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (sample_in.valid),
  .in_ready     (sample_in.ready),
  .out_valid    (mix_out.valid),
  .out_ready    (mix_out.ready),
  .mixed_sample (mix_out.mixed_sample),
  .peak_one     (mix_out.peak_one),
  .peak_two     (mix_out.peak_two)
);

// File: test/cfm_mix_checker.sv
`timescale 1ns / 1ps

module cfm_mix_checker #(
  parameter int SAMPLE_BITS = cfm_pkg::SAMPLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  cfm_in_if    in_ch,
  cfm_out_if   out_ch,
  cfm_cfg_if   cfg_ch,
  output int   failures,
  output int   pending,
  output int   checked,
  output int   periods
);
  import cfm_pkg::*;

  localparam longint UNITY = 128;
  localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] mixed;
    logic signed [SAMPLE_BITS-1:0] peak_one;
    logic signed [SAMPLE_BITS-1:0] peak_two;
    logic                          updated;
  } mix_result_t;

  cfm_cfg_t    settings;
  longint      run_one, run_two, hold_one, hold_two;
  bit          fresh_period;
  mix_result_t mix_expected[$];
  mix_result_t head;

  function automatic longint floor_div(longint num, longint den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  function automatic mix_result_t mix_and_meter(longint x1, longint x2,
                                                logic act1, logic act2, logic last);
    longint      w1_num, w1_den, w2_num, w2_den, c1, c2, mix;
    mix_result_t r;
    w1_num = 1;
    w1_den = 1;
    w2_num = 1;
    w2_den = 1;
    c1 = 0;
    c2 = 0;
    if (act1 && act2) begin
      if (settings.fader_position > FADER_CENTER) begin
        w1_num = longint'(FADER_TOP) - longint'(settings.fader_position);
        w1_den = longint'(FADER_TOP) - longint'(FADER_CENTER);
      end else if (settings.fader_position < FADER_CENTER) begin
        w2_num = longint'(settings.fader_position);
        w2_den = longint'(FADER_CENTER);
      end
      c1 = floor_div(x1 * longint'(settings.gain_one) * w1_num, UNITY * w1_den);
      c2 = floor_div(x2 * longint'(settings.gain_two) * w2_num, UNITY * w2_den);
    end else if (act1) begin
      c1 = floor_div(x1 * longint'(settings.gain_one), UNITY);
    end else if (act2) begin
      c2 = floor_div(x2 * longint'(settings.gain_two), UNITY);
    end

    mix = floor_div((c1 + c2) * longint'(settings.master_gain), UNITY);
    if (mix > SAT_HI) mix = SAT_HI;
    if (mix < SAT_LO) mix = SAT_LO;

    if (fresh_period) begin
      run_one = c1;
      run_two = c2;
    end else begin
      if (c1 > run_one) run_one = c1;
      if (c2 > run_two) run_two = c2;
    end
    fresh_period = 1'b0;
    r.updated = 1'b0;
    if (last) begin
      hold_one = run_one;
      hold_two = run_two;
      fresh_period = 1'b1;
      r.updated = 1'b1;
    end

    r.mixed = mix[SAMPLE_BITS-1:0];
    r.peak_one = hold_one[SAMPLE_BITS-1:0];
    r.peak_two = hold_two[SAMPLE_BITS-1:0];
    return r;
  endfunction

  task automatic compare_field(input string name,
                               input logic signed [SAMPLE_BITS-1:0] want,
                               input logic signed [SAMPLE_BITS-1:0] got);
    if (got !== want) begin
      failures++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      settings = '{GAIN_RESET, GAIN_RESET, GAIN_RESET, FADER_CENTER};
      run_one = 0;
      run_two = 0;
      hold_one = 0;
      hold_two = 0;
      fresh_period = 1'b1;
      mix_expected.delete();
      failures = 0;
      checked = 0;
      periods = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_GAIN_ONE:       settings.gain_one = cfg_ch.data;
          REG_GAIN_TWO:       settings.gain_two = cfg_ch.data;
          REG_MASTER_GAIN:    settings.master_gain = cfg_ch.data;
          REG_FADER_POSITION: settings.fader_position = cfg_ch.data;
          default: ;
        endcase
      end

      if (out_ch.valid && out_ch.ready) begin
        checked++;
        if (mix_expected.size() == 0) begin
          failures++;
          $display("%0t: unexpected result, expected none, actual mixed %0d", $time,
                   out_ch.mixed_sample);
        end else begin
          head = mix_expected.pop_front();
          if (head.updated) periods++;
          compare_field("mixed_sample", head.mixed, out_ch.mixed_sample);
          compare_field("peak_one", head.peak_one, out_ch.peak_one);
          compare_field("peak_two", head.peak_two, out_ch.peak_two);
          compare_field("peaks_updated", head.updated, out_ch.peaks_updated);
        end
      end

      if (in_ch.valid && in_ch.ready)
        mix_expected.insert(mix_expected.size(),
                            mix_and_meter(in_ch.sample_one, in_ch.sample_two,
                                          in_ch.one_active, in_ch.two_active,
                                          in_ch.period_last));
    end
    pending = mix_expected.size();
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import cfm_pkg::*;

  localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
  localparam int ITEM_TARGET = 600;
  localparam int CALM_ITEMS = 100;
  localparam int HOLD_CYCLES = 300;
  localparam int PRESSURE_PHASE = 2;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 32;
  localparam int REG_COUNT = 4;
  localparam int INDEX_TOP = (1 << CFG_INDEX_BITS) - 1;
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic clk;
  logic rst;
  int   failures, pending, checked, periods;
  int   items_sent, cfg_writes, settings_used;
  bit   source_gaps, sink_gaps, hold_request;

  cfm_in_if #(.SAMPLE_BITS(SAMPLE_BITS))  in_ch ();
  cfm_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();
  cfm_cfg_if                              cfg_ch ();

  two_channel_crossfade_mixer #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
    .clk       (clk),
    .rst       (rst),
    .sample_in (in_ch),
    .mix_out   (out_ch),
    .cfg       (cfg_ch)
  );

  cfm_mix_checker #(.SAMPLE_BITS(SAMPLE_BITS)) mix_check (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_ch   (cfg_ch),
    .failures (failures),
    .pending  (pending),
    .checked  (checked),
    .periods  (periods)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return S_MAX;
      1: return S_MIN;
      2: return SAMPLE_BITS'(int'($urandom_range(0, 128)) - 64);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_BITS-1:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return GAIN_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_BITS-1:0] rand_fader();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return FADER_TOP;
      2: return FADER_CENTER;
      3: return FADER_CENTER + 1'b1;
      4: return FADER_CENTER - 1'b1;
      default: return GAIN_BITS'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic signed [SAMPLE_BITS-1:0] s1,
                           input logic signed [SAMPLE_BITS-1:0] s2,
                           input logic a1, input logic a2, input logic last);
    if (source_gaps && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample_one <= s1;
    in_ch.sample_two <= s2;
    in_ch.one_active <= a1;
    in_ch.two_active <= a2;
    in_ch.period_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [GAIN_BITS-1:0] g1, input logic [GAIN_BITS-1:0] g2,
                                input logic [GAIN_BITS-1:0] gm, input logic [GAIN_BITS-1:0] fp,
                                input bit stray);
    logic [CFG_INDEX_BITS-1:0] idx[$];
    logic [GAIN_BITS-1:0]      val[$];
    idx = '{REG_GAIN_ONE, REG_GAIN_TWO, REG_MASTER_GAIN, REG_FADER_POSITION};
    val = '{g1, g2, gm, fp};
    if (stray || $urandom_range(0, 3) == 0) begin
      idx.insert(idx.size(), CFG_INDEX_BITS'($urandom_range(REG_COUNT, INDEX_TOP)));
      val.insert(val.size(), GAIN_BITS'($urandom));
    end
    for (int k = 0; k < idx.size(); k++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[k];
      cfg_ch.data <= val[k];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    cfg_writes += idx.size();
    settings_used++;
  endtask

  initial begin
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int phase;
    int count;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.sample_one = '0;
    in_ch.sample_two = '0;
    in_ch.one_active = 1'b0;
    in_ch.two_active = 1'b0;
    in_ch.period_last = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    source_gaps = 1'b0;
    sink_gaps = 1'b0;
    hold_request = 1'b0;
    items_sent = 0;
    cfg_writes = 0;
    settings_used = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(S_MAX, S_MIN, 1'b1, 1'b1, 1'b0);
    send_item(S_MIN, S_MAX, 1'b1, 1'b1, 1'b1);
    drain();
    apply_settings('1, '1, '1, FADER_CENTER, 1'b1);
    send_item(S_MAX, S_MAX, 1'b1, 1'b1, 1'b0);
    send_item(S_MIN, S_MIN, 1'b1, 1'b1, 1'b0);
    send_item(S_MAX, S_MIN, 1'b1, 1'b0, 1'b0);
    send_item(S_MIN, S_MAX, 1'b0, 1'b1, 1'b0);
    send_item(SAMPLE_BITS'(1234), SAMPLE_BITS'(-1234), 1'b0, 1'b0, 1'b1);
    send_item(SAMPLE_BITS'(-5), SAMPLE_BITS'(-7), 1'b1, 1'b1, 1'b1);
    drain();
    apply_settings(GAIN_BITS'(100), GAIN_BITS'(90), '1, FADER_TOP, 1'b0);
    send_item(SAMPLE_BITS'(20000), SAMPLE_BITS'(-20000), 1'b1, 1'b1, 1'b0);
    send_item(SAMPLE_BITS'(-1), SAMPLE_BITS'(1), 1'b1, 1'b1, 1'b1);
    drain();
    apply_settings('1, '1, '1, '0, 1'b0);
    send_item(S_MIN, S_MAX, 1'b1, 1'b1, 1'b0);
    send_item(SAMPLE_BITS'(300), SAMPLE_BITS'(-3), 1'b1, 1'b1, 1'b1);
    drain();
    apply_settings('1, '1, GAIN_BITS'(64), FADER_CENTER + 1'b1, 1'b0);
    send_item(S_MIN, S_MIN, 1'b1, 1'b1, 1'b0);
    drain();
    apply_settings('1, '1, GAIN_BITS'(64), FADER_CENTER - 1'b1, 1'b0);
    send_item(S_MAX, S_MAX, 1'b1, 1'b1, 1'b1);
    drain();
    apply_settings('0, '0, '0, FADER_CENTER, 1'b0);
    send_item(S_MAX, S_MIN, 1'b1, 1'b1, 1'b1);
    drain();
    apply_settings(GAIN_BITS'(1), GAIN_BITS'(1), '1, GAIN_BITS'(100), 1'b0);
    send_item(SAMPLE_BITS'(-1), SAMPLE_BITS'(-1), 1'b1, 1'b1, 1'b0);
    send_item(SAMPLE_BITS'(1), S_MIN, 1'b1, 1'b1, 1'b1);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      drain();
      apply_settings(rand_gain(), rand_gain(), rand_gain(), rand_fader(), 1'b0);
      source_gaps = $urandom_range(0, 2) != 0;
      sink_gaps = $urandom_range(0, 2) != 0;
      if (phase == PRESSURE_PHASE) begin
        hold_request = 1'b1;
        source_gaps = 1'b0;
      end
      count = $urandom_range(20, 60);
      repeat (count) begin
        if (ITEM_TARGET - items_sent <= CALM_ITEMS) begin
          source_gaps = 1'b0;
          sink_gaps = 1'b0;
        end
        send_item(rand_sample(), rand_sample(), $urandom_range(0, 3) != 0,
                  $urandom_range(0, 3) != 0, $urandom_range(0, 7) == 0);
      end
      phase++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("mixed %0d samples under %0d register settings (%0d register writes)",
             items_sent, settings_used, cfg_writes);
    $display("%0d results compared, %0d meter periods closed", checked, periods);
    if (failures == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// File: two_channel_crossfade_mixer.f
hdl/cfm_pkg.sv
hdl/cfm_if.sv
hdl/cfm_regs.sv
hdl/cfm_ctrl.sv
hdl/cfm_datapath.sv
hdl/two_channel_crossfade_mixer.sv
hdl/cfm_checker.sv
test/cfm_mix_checker.sv
test/tb.sv
